// ----- sv/slcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// slcfp_pkg
// Shared types, constants and the byte-wide CRC-16 update for the frame parser.
// ----------------------------------------------------------------------------
package slcfp_pkg;

  localparam logic [7:0]  SYNC_A   = 8'h5A;
  localparam logic [7:0]  SYNC_B   = 8'hA5;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_LENLO = 3'd2,
    PH_LENHI = 3'd3,
    PH_CRCLO = 3'd4,
    PH_CRCHI = 3'd5,
    PH_DATA  = 3'd6
  } phase_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_end;
    logic        crc_ok;
  } result_t;

  // msb-first crc-16, no reflection, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // crc after the sync pair, starting from zero
  localparam logic [15:0] CRC_AFTER_SYNC = crc16_byte(crc16_byte(16'h0000, SYNC_A), SYNC_B);

endpackage

// ----- sv/sync_length_crc_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// sync_length_crc_frame_parser_unit
// Frame parser for a serial byte stream: hunts for sync 0x5A 0xA5, reads a
// little-endian 16-bit length and 16-bit CRC, then reports each payload byte
// with its index, marking the last one with frame_end and a CRC-16 (0x1021,
// init 0) match over sync, length and payload. Every input byte yields one
// result transaction; non-payload bytes give an all-zero result. One byte per
// cycle unless out_stall holds; path is the input register, then the header
// state machine and byte-wide CRC feeding the result register.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic        out_frame_end,
  output logic        out_crc_ok
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               out_valid_r;
  slcfp_pkg::result_t out_result_r;
  slcfp_pkg::result_t result;
  logic               s1_adv;
  logic               in_fire;

  // stage 1 moves on when the result register is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  slcfp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (s1_adv),
    .byte_i   (s1_byte_r),
    .result_o (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_result_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = out_result_r.payload_valid;
  assign out_payload_byte  = out_result_r.payload_byte;
  assign out_payload_index = out_result_r.payload_index;
  assign out_frame_end     = out_result_r.frame_end;
  assign out_crc_ok        = out_result_r.crc_ok;

endmodule

// ----- sv/slcfp_crc.sv -----
// ----------------------------------------------------------------------------
// slcfp_crc
// Byte-wide unrolled CRC-16 (poly 0x1021) update.
// ----------------------------------------------------------------------------
module slcfp_crc (
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  assign crc_o = slcfp_pkg::crc16_byte(crc_i, byte_i);

endmodule

// ----- sv/slcfp_parser.sv -----
// ----------------------------------------------------------------------------
// slcfp_parser
// Header/payload state machine with running CRC; one byte per transaction.
// ----------------------------------------------------------------------------
module slcfp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  output slcfp_pkg::result_t  result_o
);

  slcfp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] frame_length_r, frame_length_nxt;
  logic [15:0] received_crc_r, received_crc_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;

  logic [15:0] crc_upd;
  logic [16:0] count_inc;
  logic        last_byte;

  slcfp_crc u_crc (
    .crc_i  (running_crc_r),
    .byte_i (byte_i),
    .crc_o  (crc_upd)
  );

  assign count_inc = {1'b0, byte_count_r} + 17'd1;
  // length 0 and 1 both end on the first payload byte
  assign last_byte = (count_inc >= {1'b0, frame_length_r});

  // next state
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      slcfp_pkg::PH_IDLE: begin
        if (byte_i == slcfp_pkg::SYNC_A) phase_nxt = slcfp_pkg::PH_SYNC2;
      end
      slcfp_pkg::PH_SYNC2: begin
        // a wrong second sync byte keeps waiting
        if (byte_i == slcfp_pkg::SYNC_B) phase_nxt = slcfp_pkg::PH_LENLO;
      end
      slcfp_pkg::PH_LENLO: phase_nxt = slcfp_pkg::PH_LENHI;
      slcfp_pkg::PH_LENHI: phase_nxt = slcfp_pkg::PH_CRCLO;
      slcfp_pkg::PH_CRCLO: phase_nxt = slcfp_pkg::PH_CRCHI;
      slcfp_pkg::PH_CRCHI: phase_nxt = slcfp_pkg::PH_DATA;
      slcfp_pkg::PH_DATA: begin
        if (last_byte) phase_nxt = slcfp_pkg::PH_IDLE;
      end
      default: phase_nxt = slcfp_pkg::PH_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    frame_length_nxt = frame_length_r;
    received_crc_nxt = received_crc_r;
    running_crc_nxt  = running_crc_r;
    byte_count_nxt   = byte_count_r;
    result_o         = '0;
    unique case (phase_r)
      slcfp_pkg::PH_IDLE: begin
      end
      slcfp_pkg::PH_SYNC2: begin
        if (byte_i == slcfp_pkg::SYNC_B) running_crc_nxt = slcfp_pkg::CRC_AFTER_SYNC;
      end
      slcfp_pkg::PH_LENLO: begin
        frame_length_nxt = {8'h00, byte_i};
        running_crc_nxt  = crc_upd;
      end
      slcfp_pkg::PH_LENHI: begin
        frame_length_nxt = {byte_i, frame_length_r[7:0]};
        running_crc_nxt  = crc_upd;
      end
      slcfp_pkg::PH_CRCLO: begin
        received_crc_nxt = {8'h00, byte_i};
      end
      slcfp_pkg::PH_CRCHI: begin
        received_crc_nxt = {byte_i, received_crc_r[7:0]};
        byte_count_nxt   = 16'h0000;
      end
      slcfp_pkg::PH_DATA: begin
        running_crc_nxt        = crc_upd;
        byte_count_nxt         = count_inc[15:0];
        result_o.payload_valid = 1'b1;
        result_o.payload_byte  = byte_i;
        result_o.payload_index = byte_count_r;
        result_o.frame_end     = last_byte;
        result_o.crc_ok        = last_byte && (crc_upd == received_crc_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= slcfp_pkg::PH_IDLE;
      frame_length_r <= 16'h0000;
      received_crc_r <= 16'h0000;
      running_crc_r  <= 16'h0000;
      byte_count_r   <= 16'h0000;
    end else if (fire_i) begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      received_crc_r <= received_crc_nxt;
      running_crc_r  <= running_crc_nxt;
      byte_count_r   <= byte_count_nxt;
    end
  end

endmodule
